// ===== src/jsge_pkg.sv =====
`default_nettype none
package jsge_pkg;

	localparam int DATA_W    = 32;
	localparam int ACC_W     = DATA_W + 2;
	localparam int IDX_W     = 6;
	localparam int FUNC_W    = 2;
	localparam int DIM_W     = 7;
	localparam int SWEEP_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PHASE_W   = 3;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam logic [DIM_W-1:0]   GRID_ROWS_RST   = 7'd64;
	localparam logic [DIM_W-1:0]   GRID_COLS_RST   = 7'd64;
	localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD = 2'd0,
		FN_RUN  = 2'd1,
		FN_READ = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_ROWS   = 2'd0,
		CFG_GRID_COLS   = 2'd1,
		CFG_SWEEP_COUNT = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_reg_t;

	// stencil tap order within one cell
	typedef enum logic [PHASE_W-1:0] {
		PH_UP    = 3'd0,
		PH_DOWN  = 3'd1,
		PH_LEFT  = 3'd2,
		PH_RIGHT = 3'd3,
		PH_WRITE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP_START,
		ST_CELL,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== src/jacobi_stencil_grid_engine_unit.sv =====
// Five-point Jacobi stencil engine on a grid of signed Q16.16 cells, held in two
// banks of MAX_ROWS x MAX_COLS words (row-major, row stride MAX_COLS).
// Input channel (in_valid/in_stall) carries one command beat: load a cell into
// both banks, run sweep_count sweeps, or read a cell from the current bank.
// Output channel (out_valid/out_stall) returns exactly one beat per command:
// cell_out (read data, else zero) and op_status (1 = row/col outside grid).
// Load: result registered on the accept edge, one beat per cycle sustained while out_stall is low.
// Read: one registered memory read, then the result register once out_free.
// Run: a single adder visits each interior cell in five steps (four neighbor
// reads through the one read port of the current bank, then a write into the
// other bank). With fewer than three rows or columns each sweep only swaps banks.
// A run with sweep_count zero completes like a load.
// in_stall is high while a command is in progress and while a finished beat is
// held by out_stall; the output register keeps its beat until taken.
// Reset clears control state and registers (rows 64, cols 64, sweeps 1, bank a
// current). Grid contents are undefined until loaded; no clearing pass.
// Configuration writes (cfg_write) are taken at any edge, meant for idle time.
`default_nettype none
module jacobi_stencil_grid_engine_unit #(
	parameter int MAX_ROWS = jsge_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = jsge_pkg::DEF_MAX_COLS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [jsge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [jsge_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [jsge_pkg::FUNC_W-1:0]         func,
	input  wire logic [jsge_pkg::IDX_W-1:0]          row_index,
	input  wire logic [jsge_pkg::IDX_W-1:0]          col_index,
	input  wire logic signed [jsge_pkg::DATA_W-1:0]  cell_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [jsge_pkg::DATA_W-1:0]       cell_out,
	output logic                                     op_status
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] COL_STEP = AW'(MAX_COLS);
	localparam logic [AW-1:0] ONE_A    = AW'(1);
	localparam int DW  = jsge_pkg::DATA_W;
	localparam int NW  = jsge_pkg::DIM_W;
	localparam int SW  = jsge_pkg::SWEEP_W;
	localparam int ACW = jsge_pkg::ACC_W;
	localparam int PW  = jsge_pkg::PHASE_W;

	// banks
	logic [DW-1:0] bank_a [DEPTH];
	logic [DW-1:0] bank_b [DEPTH];
	logic [DW-1:0] rd_a_q, rd_b_q;

	// config
	logic [NW-1:0] grid_rows_q, grid_cols_q;
	logic [SW-1:0] sweep_count_q;

	// control and datapath
	jsge_pkg::state_t state_q, state_d;
	logic [PW-1:0]    phase_q, phase_d;
	logic [NW-1:0]    i_q, i_d, j_q, j_d;
	logic [NW-1:0]    rows_q, rows_d, cols_q, cols_d;
	logic [AW-1:0]    ctr_q, ctr_d, base_q, base_d;
	logic [SW-1:0]    sweeps_q, sweeps_d;
	logic [ACW-1:0]   acc_q, acc_d;
	logic             bank_q, bank_d;
	logic             out_valid_q, out_valid_d;
	logic [DW-1:0]    cell_out_q, cell_out_d;
	logic             op_status_q, op_status_d;

	// memory controls
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_a, wr_b;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;

	logic [NW-1:0]  eff_rows, eff_cols;
	logic           out_free, accept, outside;
	logic [AW-1:0]  host_addr;
	logic [DW-1:0]  rd_cur;
	logic [ACW-1:0] rd_ext, sum;

	always_comb begin
		eff_rows = (int'(grid_rows_q) > MAX_ROWS) ? NW'(MAX_ROWS) : grid_rows_q;
		eff_cols = (int'(grid_cols_q) > MAX_COLS) ? NW'(MAX_COLS) : grid_cols_q;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == jsge_pkg::ST_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign outside   = ({1'b0, row_index} >= eff_rows) || ({1'b0, col_index} >= eff_cols);
	assign host_addr = AW'(int'(row_index) * MAX_COLS + int'(col_index));
	assign rd_cur    = bank_q ? rd_b_q : rd_a_q;
	assign rd_ext    = {{(ACW-DW){rd_cur[DW-1]}}, rd_cur};
	assign sum       = acc_q + rd_ext;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		i_d         = i_q;
		j_d         = j_q;
		rows_d      = rows_q;
		cols_d      = cols_q;
		ctr_d       = ctr_q;
		base_d      = base_q;
		sweeps_d    = sweeps_q;
		acc_d       = acc_q;
		bank_d      = bank_q;
		out_valid_d = out_valid_q && out_stall;
		cell_out_d  = cell_out_q;
		op_status_d = op_status_q;
		rd_en       = 1'b0;
		rd_addr     = host_addr;
		wr_a        = 1'b0;
		wr_b        = 1'b0;
		wr_addr     = host_addr;
		wr_data     = cell_in;

		case (state_q)
			jsge_pkg::ST_IDLE: begin
				if (accept) begin
					case (jsge_pkg::func_t'(func))
						jsge_pkg::FN_LOAD: begin
							wr_a        = !outside;
							wr_b        = !outside;
							out_valid_d = 1'b1;
							cell_out_d  = '0;
							op_status_d = outside;
						end
						jsge_pkg::FN_READ: begin
							if (outside) begin
								out_valid_d = 1'b1;
								cell_out_d  = '0;
								op_status_d = 1'b1;
							end else begin
								rd_en   = 1'b1;
								state_d = jsge_pkg::ST_READ;
							end
						end
						jsge_pkg::FN_RUN: begin
							if (sweep_count_q == '0) begin
								out_valid_d = 1'b1;
								cell_out_d  = '0;
								op_status_d = 1'b0;
							end else begin
								rows_d   = eff_rows;
								cols_d   = eff_cols;
								sweeps_d = sweep_count_q;
								state_d  = jsge_pkg::ST_SWEEP_START;
							end
						end
						default: begin
							out_valid_d = 1'b1;
							cell_out_d  = '0;
							op_status_d = 1'b0;
						end
					endcase
				end
			end
			jsge_pkg::ST_READ: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					cell_out_d  = rd_cur;
					op_status_d = 1'b0;
					state_d     = jsge_pkg::ST_IDLE;
				end
			end
			jsge_pkg::ST_SWEEP_START: begin
				i_d     = NW'(1);
				j_d     = NW'(1);
				base_d  = COL_STEP;
				ctr_d   = COL_STEP + ONE_A;
				phase_d = jsge_pkg::PH_UP;
				if (rows_q >= NW'(3) && cols_q >= NW'(3)) begin
					state_d = jsge_pkg::ST_CELL;
				end else begin
					// no interior: the sweep only swaps banks
					bank_d   = !bank_q;
					sweeps_d = sweeps_q - SW'(1);
					if (sweeps_q == SW'(1))
						state_d = jsge_pkg::ST_DONE;
				end
			end
			jsge_pkg::ST_CELL: begin
				rd_en   = 1'b1;
				phase_d = phase_q + PW'(1);
				case (jsge_pkg::phase_t'(phase_q))
					jsge_pkg::PH_UP: begin
						rd_addr = ctr_q - COL_STEP;
					end
					jsge_pkg::PH_DOWN: begin
						rd_addr = ctr_q + COL_STEP;
						acc_d   = rd_ext;
					end
					jsge_pkg::PH_LEFT: begin
						rd_addr = ctr_q - ONE_A;
						acc_d   = sum;
					end
					jsge_pkg::PH_RIGHT: begin
						rd_addr = ctr_q + ONE_A;
						acc_d   = sum;
					end
					default: begin
						rd_en   = 1'b0;
						// floor(sum/4): drop the two low bits of the 34-bit sum
						wr_addr = ctr_q;
						wr_data = sum[ACW-1:2];
						wr_a    = bank_q;
						wr_b    = !bank_q;
						phase_d = jsge_pkg::PH_UP;
						if (j_q == cols_q - NW'(2)) begin
							if (i_q == rows_q - NW'(2)) begin
								bank_d   = !bank_q;
								sweeps_d = sweeps_q - SW'(1);
								state_d  = (sweeps_q == SW'(1)) ? jsge_pkg::ST_DONE
								                                 : jsge_pkg::ST_SWEEP_START;
							end else begin
								i_d    = i_q + NW'(1);
								j_d    = NW'(1);
								base_d = base_q + COL_STEP;
								ctr_d  = base_q + COL_STEP + ONE_A;
							end
						end else begin
							j_d   = j_q + NW'(1);
							ctr_d = ctr_q + ONE_A;
						end
					end
				endcase
			end
			jsge_pkg::ST_DONE: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					cell_out_d  = '0;
					op_status_d = 1'b0;
					state_d     = jsge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jsge_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_a)
			bank_a[wr_addr] <= wr_data;
		if (rd_en)
			rd_a_q <= bank_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			bank_b[wr_addr] <= wr_data;
		if (rd_en)
			rd_b_q <= bank_b[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= jsge_pkg::GRID_ROWS_RST;
			grid_cols_q   <= jsge_pkg::GRID_COLS_RST;
			sweep_count_q <= jsge_pkg::SWEEP_COUNT_RST;
		end else if (cfg_write) begin
			case (jsge_pkg::cfg_reg_t'(cfg_index))
				jsge_pkg::CFG_GRID_ROWS:   grid_rows_q   <= cfg_data[NW-1:0];
				jsge_pkg::CFG_GRID_COLS:   grid_cols_q   <= cfg_data[NW-1:0];
				jsge_pkg::CFG_SWEEP_COUNT: sweep_count_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jsge_pkg::ST_IDLE;
			phase_q     <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sweeps_q    <= '0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			bank_q      <= bank_d;
			out_valid_q <= out_valid_d;
			sweeps_q    <= sweeps_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		rows_q      <= rows_d;
		cols_q      <= cols_d;
		ctr_q       <= ctr_d;
		base_q      <= base_d;
		acc_q       <= acc_d;
		cell_out_q  <= cell_out_d;
		op_status_q <= op_status_d;
	end

	assign out_valid = out_valid_q;
	assign cell_out  = cell_out_q;
	assign op_status = op_status_q;

	// banks swap only at the end of a sweep
	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |->
		($past(state_q) == jsge_pkg::ST_CELL || $past(state_q) == jsge_pkg::ST_SWEEP_START))
		else $error("bank swap outside a sweep");

	// the stencil walk stays on interior cells
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jsge_pkg::ST_CELL) |->
		(i_q != '0 && j_q != '0 &&
		 ({1'b0, i_q} + 8'd2) <= {1'b0, rows_q} && ({1'b0, j_q} + 8'd2) <= {1'b0, cols_q}))
		else $error("stencil cell outside interior");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jsge_pkg::ST_CELL) |-> (phase_q <= PW'(jsge_pkg::PH_WRITE)))
		else $error("cell phase out of range");

	// a waiting beat is never overwritten or dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(cell_out_q) && $stable(op_status_q)))
		else $error("stalled result beat lost");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_STRIDE    = jsge_pkg::DEF_MAX_COLS;
	localparam int GRID_CELLS     = jsge_pkg::DEF_MAX_ROWS * jsge_pkg::DEF_MAX_COLS;
	localparam int TARGET_ITEMS   = 1850;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int COSTLY_RUN     = 20000;
	localparam bit DONE_OK        = 1'b0;
	localparam bit OUT_OF_GRID    = 1'b1;

	typedef struct {
		jsge_pkg::func_t                op;
		logic [jsge_pkg::IDX_W-1:0]     row;
		logic [jsge_pkg::IDX_W-1:0]     col;
		logic [jsge_pkg::DATA_W-1:0]    value;
	} stencil_cmd_t;

	typedef struct {
		logic [jsge_pkg::DATA_W-1:0] cell_val;
		logic                        status;
	} cell_result_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_write = 1'b0;
	logic [jsge_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [jsge_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [jsge_pkg::FUNC_W-1:0]          func = '0;
	logic [jsge_pkg::IDX_W-1:0]           row_index = '0;
	logic [jsge_pkg::IDX_W-1:0]           col_index = '0;
	logic signed [jsge_pkg::DATA_W-1:0]   cell_in = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [jsge_pkg::DATA_W-1:0]   cell_out;
	logic                                 op_status;

	jacobi_stencil_grid_engine_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.row_index (row_index),
		.col_index (col_index),
		.cell_in   (cell_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cell_out  (cell_out),
		.op_status (op_status)
	);

	// shadow of the engine: both banks, bank select and the registers
	bit [jsge_pkg::DATA_W-1:0]  grid [2][GRID_CELLS];
	bit                         cur_bank = 1'b0;
	bit [jsge_pkg::DIM_W-1:0]   rows_cfg = jsge_pkg::GRID_ROWS_RST;
	bit [jsge_pkg::DIM_W-1:0]   cols_cfg = jsge_pkg::GRID_COLS_RST;
	bit [jsge_pkg::SWEEP_W-1:0] sweeps_cfg = jsge_pkg::SWEEP_COUNT_RST;

	stencil_cmd_t pending_cmds[$];
	cell_result_t cell_results_q[$];
	int           mismatches = 0;
	int           queued_items = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int eff_dim(int cfg, int max_dim);
		return (cfg > max_dim) ? max_dim : cfg;
	endfunction

	function automatic logic [jsge_pkg::DATA_W+1:0] widen(logic [jsge_pkg::DATA_W-1:0] v);
		return {{2{v[jsge_pkg::DATA_W-1]}}, v};
	endfunction

	function automatic void sweep_grid(int er, int ec);
		logic [jsge_pkg::DATA_W+1:0] acc;
		int                          k;
		bit                          nb;
		nb = ~cur_bank;
		if (er >= 3 && ec >= 3) begin
			for (int i = 1; i < er - 1; i++) begin
				for (int j = 1; j < ec - 1; j++) begin
					k = i * GRID_STRIDE + j;
					acc = widen(grid[cur_bank][k - GRID_STRIDE]) +
					      widen(grid[cur_bank][k + GRID_STRIDE]) +
					      widen(grid[cur_bank][k - 1]) + widen(grid[cur_bank][k + 1]);
					// floor of sum/4 == arithmetic shift by 2
					grid[nb][k] = acc[jsge_pkg::DATA_W+1:2];
				end
			end
		end
		cur_bank = nb;
	endfunction

	function automatic cell_result_t stencil_predict(stencil_cmd_t c);
		cell_result_t res;
		int           er;
		int           ec;
		int           k;
		res.cell_val = '0;
		res.status = DONE_OK;
		er = eff_dim(rows_cfg, jsge_pkg::DEF_MAX_ROWS);
		ec = eff_dim(cols_cfg, jsge_pkg::DEF_MAX_COLS);
		case (c.op)
			jsge_pkg::FN_LOAD, jsge_pkg::FN_READ: begin
				if (c.row >= er || c.col >= ec) begin
					res.status = OUT_OF_GRID;
				end else begin
					k = c.row * GRID_STRIDE + c.col;
					if (c.op == jsge_pkg::FN_LOAD) begin
						grid[0][k] = c.value;
						grid[1][k] = c.value;
					end else begin
						res.cell_val = grid[cur_bank][k];
					end
				end
			end
			jsge_pkg::FN_RUN: begin
				for (int s = 0; s < sweeps_cfg; s++)
					sweep_grid(er, ec);
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// ---------------- driver: bursts with random gaps ----------------
	stencil_cmd_t cmd_now;
	int           burst_left = 0;
	int           gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= '0;
			row_index <= '0;
			col_index <= '0;
			cell_in <= '0;
		end else begin
			if (in_valid && !in_stall)
				cell_results_q.push_back(stencil_predict(cmd_now));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_now = pending_cmds.pop_front();
					in_valid <= 1'b1;
					func <= cmd_now.op;
					row_index <= cmd_now.row;
					col_index <= cmd_now.col;
					cell_in <= cmd_now.value;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver stall pattern ----------------
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(8, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 80);
				default: out_stall <= stall_left[1];
			endcase
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cell_results_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat cell_out %h op_status %b",
					cell_out, op_status));
			end else begin
				want = cell_results_q.pop_front();
				if (cell_out !== want.cell_val)
					flag_mismatch($sformatf("cell_out %h, want %h", cell_out, want.cell_val));
				if (op_status !== want.status)
					flag_mismatch($sformatf("op_status %b, want %b", op_status, want.status));
			end
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic void queue_cmd(jsge_pkg::func_t op, int r, int c,
		logic [jsge_pkg::DATA_W-1:0] v);
		stencil_cmd_t cmd;
		cmd.op = op;
		cmd.row = jsge_pkg::IDX_W'(r);
		cmd.col = jsge_pkg::IDX_W'(c);
		cmd.value = v;
		pending_cmds.push_back(cmd);
		if (op != jsge_pkg::FN_NOP)
			queued_items++;
	endfunction

	function automatic logic [jsge_pkg::DATA_W-1:0] pick_cell();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return jsge_pkg::DATA_W'($urandom_range(0, 511) - 256);
			default: return $urandom();
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 11))
			0: return $urandom_range(0, 2);
			1: return $urandom_range(65, 127);
			2: return $urandom_range(9, 64);
			default: return $urandom_range(3, 8);
		endcase
	endfunction

	// wait until every queued beat went in and every result came back
	task automatic drain();
		@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || cell_results_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(jsge_pkg::cfg_reg_t idx, int val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= jsge_pkg::CFG_DATA_W'(val);
		case (idx)
			jsge_pkg::CFG_GRID_ROWS:   rows_cfg = jsge_pkg::DIM_W'(val);
			jsge_pkg::CFG_GRID_COLS:   cols_cfg = jsge_pkg::DIM_W'(val);
			jsge_pkg::CFG_SWEEP_COUNT: sweeps_cfg = jsge_pkg::SWEEP_W'(val);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(int rows, int cols, int sweeps, int n_mixed);
		int er;
		int ec;
		int cost;
		int run_cap;
		int runs;
		int roll;
		int r;
		int c;
		bit in_ok;
		bit oor_ok;
		drain();
		write_reg(jsge_pkg::CFG_GRID_ROWS, rows);
		write_reg(jsge_pkg::CFG_GRID_COLS, cols);
		write_reg(jsge_pkg::CFG_SWEEP_COUNT, sweeps);
		@(negedge clk);
		er = eff_dim(rows, jsge_pkg::DEF_MAX_ROWS);
		ec = eff_dim(cols, jsge_pkg::DEF_MAX_COLS);
		cost = sweeps * (1 + 5 * ((er > 2) ? er - 2 : 0) * ((ec > 2) ? ec - 2 : 0));
		run_cap = (cost > COSTLY_RUN) ? 2 : n_mixed;
		runs = 0;
		in_ok = (er > 0 && ec > 0);
		oor_ok = (er < jsge_pkg::DEF_MAX_ROWS || ec < jsge_pkg::DEF_MAX_COLS);
		// fill the whole active region so that every later in-grid read hits a written cell
		for (int i = 0; i < er; i++)
			for (int j = 0; j < ec; j++)
				queue_cmd(jsge_pkg::FN_LOAD, i, j, pick_cell());
		for (int n = 0; n < n_mixed; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				queue_cmd(jsge_pkg::FN_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom());
			end else if (roll < 17 && runs < run_cap) begin
				runs++;
				queue_cmd(jsge_pkg::FN_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom());
			end else if ((roll < 32 && oor_ok) || !in_ok) begin
				if (er < jsge_pkg::DEF_MAX_ROWS &&
				    (ec >= jsge_pkg::DEF_MAX_COLS || $urandom_range(0, 1))) begin
					r = $urandom_range(er, 63);
					c = $urandom_range(0, 63);
				end else begin
					r = $urandom_range(0, 63);
					c = $urandom_range(ec, 63);
				end
				queue_cmd($urandom_range(0, 1) ? jsge_pkg::FN_LOAD : jsge_pkg::FN_READ,
					r, c, $urandom());
			end else begin
				r = $urandom_range(0, er - 1);
				c = $urandom_range(0, ec - 1);
				if (roll < 60)
					queue_cmd(jsge_pkg::FN_LOAD, r, c, pick_cell());
				else
					queue_cmd(jsge_pkg::FN_READ, r, c, '0);
			end
			if (n == n_mixed / 2 && $urandom_range(0, 3) == 0)
				drain();
		end
	endtask

	initial begin
		int rows;
		int cols;
		int sweeps;
		wait (arst_n);
		@(negedge clk);

		// reset geometry 64x64, one sweep: corners, extremes, one stencil cell
		queue_cmd(jsge_pkg::FN_LOAD, 0, 0, 32'h7FFF_FFFF);
		queue_cmd(jsge_pkg::FN_READ, 0, 0, '0);
		queue_cmd(jsge_pkg::FN_LOAD, 63, 63, 32'hFFFF_FFFF);
		queue_cmd(jsge_pkg::FN_LOAD, 63, 0, '0);
		queue_cmd(jsge_pkg::FN_LOAD, 0, 63, 32'h0001_0000);
		queue_cmd(jsge_pkg::FN_LOAD, 0, 1, 32'h8000_0000);
		queue_cmd(jsge_pkg::FN_LOAD, 2, 1, 32'h8000_0000);
		queue_cmd(jsge_pkg::FN_LOAD, 1, 0, 32'h8000_0000);
		queue_cmd(jsge_pkg::FN_LOAD, 1, 2, 32'h7FFF_FFFF);
		queue_cmd(jsge_pkg::FN_NOP, 63, 63, 32'hFFFF_FFFF);
		queue_cmd(jsge_pkg::FN_RUN, 0, 0, '0);
		queue_cmd(jsge_pkg::FN_READ, 1, 1, '0);
		queue_cmd(jsge_pkg::FN_READ, 63, 63, '0);
		queue_cmd(jsge_pkg::FN_READ, 0, 63, '0);
		queue_cmd(jsge_pkg::FN_READ, 63, 0, '0);
		queue_cmd(jsge_pkg::FN_READ, 0, 1, '0);

		// geometry and sweep-count corners
		run_phase(3, 3, 0, 20);
		run_phase(0, 5, 2, 15);
		run_phase(10, 0, 4, 10);
		run_phase(127, 2, 65535, 12);
		run_phase(64, 3, 3, 30);
		run_phase(3, 64, 2, 30);
		run_phase(1, 1, 7, 15);
		run_phase(2, 9, 1, 20);
		run_phase(5, 7, 1, 40);

		while (queued_items < TARGET_ITEMS) begin
			rows = pick_dim();
			if (eff_dim(rows, jsge_pkg::DEF_MAX_ROWS) > 8)
				cols = $urandom_range(0, 4);
			else
				cols = pick_dim();
			if (eff_dim(cols, jsge_pkg::DEF_MAX_COLS) > 8 &&
			    eff_dim(rows, jsge_pkg::DEF_MAX_ROWS) > 4)
				rows = $urandom_range(1, 4);
			if (eff_dim(rows, jsge_pkg::DEF_MAX_ROWS) < 3 ||
			    eff_dim(cols, jsge_pkg::DEF_MAX_COLS) < 3)
				sweeps = $urandom_range(0, 300);
			else
				sweeps = $urandom_range(0, 4);
			run_phase(rows, cols, sweeps, $urandom_range(30, 90));
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
src/jsge_pkg.sv
src/jacobi_stencil_grid_engine_unit.sv
verif/tb.sv
